// ===== rtl/pmt_pkg.sv =====
// shared types and codes for the page mapping table
`timescale 1ns / 1ps

package pmt_pkg;

    typedef enum logic [1:0] {
        OP_MAP   = 2'd0,
        OP_XLATE = 2'd1,
        OP_UNMAP = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_PERM      = 3'd4,
        ST_NOT_FOUND = 3'd5
    } t_status;

    // control part of the token that walks the cell chain
    typedef struct packed {
        logic       valid;
        t_op        op;
        logic       bad;
        logic       hit;
        logic       deny;
        logic       claimed;
        logic       dup;
        logic [7:0] perms;
    } t_tok_ctl;

    // broadcast from the chain end back to every cell
    typedef struct packed {
        logic commit;
        logic cancel;
    } t_cell_cmd;

endpackage

// ===== rtl/pmt_cell.sv =====
// one table entry plus the token stage that passes it on to the next entry
`timescale 1ns / 1ps

module pmt_cell #(
    parameter int VPN_W = 8,
    parameter int FRM_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pmt_pkg::t_tok_ctl  i_ctl,
    input  logic [VPN_W-1:0]   i_page,
    input  logic [FRM_W-1:0]   i_frame,
    input  pmt_pkg::t_cell_cmd i_cmd,
    output pmt_pkg::t_tok_ctl  o_ctl,
    output logic [VPN_W-1:0]   o_page,
    output logic [FRM_W-1:0]   o_frame
);
    import pmt_pkg::*;

    logic             r_valid, n_valid;
    logic             r_pend, n_pend;
    logic [VPN_W-1:0] r_page, n_page;
    logic [FRM_W-1:0] r_frame, n_frame;
    logic [7:0]       r_perms, n_perms;

    t_tok_ctl         r_ctl, n_ctl;
    logic [VPN_W-1:0] r_tok_page;
    logic [FRM_W-1:0] r_tok_frame, n_tok_frame;

    logic match;

    assign match = r_valid && (r_page == i_page);

    always_comb begin
        n_valid     = r_valid;
        n_pend      = r_pend;
        n_page      = r_page;
        n_frame     = r_frame;
        n_perms     = r_perms;
        n_ctl       = i_ctl;
        n_tok_frame = i_frame;

        if (i_ctl.valid && !i_ctl.bad) begin
            unique case (i_ctl.op)
                OP_MAP: begin
                    if (match) begin
                        n_ctl.dup = 1'b1;
                    end else if (!r_valid && !r_pend && !i_ctl.claimed) begin
                        // hold the slot until the whole row has been checked
                        n_pend        = 1'b1;
                        n_page        = i_page;
                        n_frame       = i_frame;
                        n_perms       = i_ctl.perms;
                        n_ctl.claimed = 1'b1;
                    end
                end
                OP_XLATE: begin
                    if (match && !i_ctl.hit) begin
                        n_ctl.hit   = 1'b1;
                        n_ctl.deny  = (r_perms & i_ctl.perms) != i_ctl.perms;
                        n_tok_frame = r_frame;
                    end
                end
                OP_UNMAP: begin
                    if (match && !i_ctl.hit) begin
                        n_ctl.hit = 1'b1;
                        n_valid   = 1'b0;
                    end
                end
                OP_CLEAR: begin
                    n_valid = 1'b0;
                    n_pend  = 1'b0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end

        if (i_cmd.commit && r_pend) begin
            n_valid = 1'b1;
            n_pend  = 1'b0;
        end
        if (i_cmd.cancel) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pend    <= 1'b0;
            r_ctl     <= '0;
        end else begin
            r_valid   <= n_valid;
            r_pend    <= n_pend;
            r_ctl     <= n_ctl;
        end
        r_page      <= n_page;
        r_frame     <= n_frame;
        r_perms     <= n_perms;
        r_tok_page  <= i_page;
        r_tok_frame <= n_tok_frame;
    end

    assign o_ctl   = r_ctl;
    assign o_page  = r_tok_page;
    assign o_frame = r_tok_frame;

endmodule

// ===== rtl/page_mapping_table.sv =====
// page mapping table top: front-end checks, cell chain, result and output registers
//
//  channel   direction  handshake              payload
//  ------------------------------------------------------------------------------
//  request   in         i_valid / o_stall      i_opcode, i_virtual_address,
//                                              i_frame_address, i_permission_bits
//  result    out        o_valid / i_stall      o_status, o_physical_address
//  config    in         i_cfg_we               i_cfg_wdata (permission mask)
//
//  each beat walks the row of ENTRY_COUNT cells, one cell per cycle, from the head token
//  register; at the row end its result goes to the done register, then to the output register, which drives o_valid.
//  one request is in the row at a time; o_stall is high while it is in flight or while
//  its result waits for the output register, so the next request is taken once that
//  result has moved into the output register, even while it still sits stalled at the
//  output. synchronous reset empties the table, mask to 7.
`timescale 1ns / 1ps

module page_mapping_table #(
    parameter int ENTRY_COUNT          = 16,
    parameter int PAGE_OFFSET_BITS     = 12,
    parameter int VIRTUAL_PAGE_COUNT   = 256,
    parameter int PHYSICAL_FRAME_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_virtual_address,
    input  logic [31:0] i_frame_address,
    input  logic [7:0]  i_permission_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_physical_address,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);
    import pmt_pkg::*;

    localparam int VPN_W = (VIRTUAL_PAGE_COUNT > 1) ? $clog2(VIRTUAL_PAGE_COUNT) : 1;
    localparam int FRM_W = (PHYSICAL_FRAME_COUNT > 1) ? $clog2(PHYSICAL_FRAME_COUNT) : 1;
    localparam int OFF_W = PAGE_OFFSET_BITS;
    localparam logic [32:0] VPN_LIMIT = 33'(VIRTUAL_PAGE_COUNT);
    localparam logic [32:0] FRM_LIMIT = 33'(PHYSICAL_FRAME_COUNT);

    logic [7:0] r_mask;

    // request checks
    logic       accept;
    t_op        op_in;
    logic       va_in_range, va_aligned, fa_in_range, fa_aligned, perms_ok, bad_in;

    // head-of-row token
    t_tok_ctl         r_tok, n_tok;
    logic [VPN_W-1:0] r_tok_page;
    logic [FRM_W-1:0] r_tok_frame;
    logic [OFF_W-1:0] r_off;
    logic             r_busy;

    // chain wiring
    t_tok_ctl         w_ctl   [0:ENTRY_COUNT];
    logic [VPN_W-1:0] w_page  [0:ENTRY_COUNT];
    logic [FRM_W-1:0] w_frame [0:ENTRY_COUNT];
    t_cell_cmd        cmd;

    // row end
    t_tok_ctl    tail;
    logic        tail_v;
    t_status     res_status;
    logic [31:0] res_phys;

    logic        r_done_v;
    t_status     r_done_status;
    logic [31:0] r_done_phys;
    logic        done_to_out;

    logic        r_out_v;
    t_status     r_out_status;
    logic [31:0] r_out_phys;

    assign accept = i_valid && !o_stall;
    assign op_in  = t_op'(i_opcode);

    assign va_in_range = {1'b0, i_virtual_address >> OFF_W} < VPN_LIMIT;
    assign fa_in_range = {1'b0, i_frame_address >> OFF_W} < FRM_LIMIT;
    assign va_aligned  = i_virtual_address[OFF_W-1:0] == '0;
    assign fa_aligned  = i_frame_address[OFF_W-1:0] == '0;
    assign perms_ok    = (i_permission_bits != 8'd0) &&
                         ((i_permission_bits & ~r_mask) == 8'd0);

    always_comb begin
        unique case (op_in)
            OP_MAP:   bad_in = !(va_in_range && va_aligned && fa_in_range && fa_aligned
                                 && perms_ok);
            OP_XLATE: bad_in = !(va_in_range && perms_ok);
            OP_UNMAP: bad_in = !(va_in_range && va_aligned);
            OP_CLEAR: bad_in = 1'b0;
            default:  bad_in = 1'b1;
        endcase
    end

    always_comb begin
        n_tok         = '0;
        n_tok.valid   = accept;
        n_tok.op      = op_in;
        n_tok.bad     = bad_in;
        n_tok.perms   = i_permission_bits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= 8'd7;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (tail_v) begin
                r_busy <= 1'b0;
            end
        end
        if (accept) begin
            r_tok_page  <= i_virtual_address[OFF_W +: VPN_W];
            r_tok_frame <= i_frame_address[OFF_W +: FRM_W];
            r_off       <= i_virtual_address[OFF_W-1:0];
        end
    end

    assign w_ctl[0]   = r_tok;
    assign w_page[0]  = r_tok_page;
    assign w_frame[0] = r_tok_frame;

    for (genvar g = 0; g < ENTRY_COUNT; g++) begin : g_cell
        pmt_cell #(
            .VPN_W (VPN_W),
            .FRM_W (FRM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_page  (w_page[g]),
            .i_frame (w_frame[g]),
            .i_cmd   (cmd),
            .o_ctl   (w_ctl[g+1]),
            .o_page  (w_page[g+1]),
            .o_frame (w_frame[g+1])
        );
    end

    assign tail   = w_ctl[ENTRY_COUNT];
    assign tail_v = tail.valid;

    // a claimed slot becomes valid only once no duplicate was seen in the row
    assign cmd.commit = tail_v && !tail.bad && (tail.op == OP_MAP) && !tail.dup
                        && tail.claimed;
    assign cmd.cancel = tail_v && !cmd.commit;

    always_comb begin
        res_status = ST_OK;
        res_phys   = 32'd0;
        if (tail.bad) begin
            res_status = ST_INVALID;
        end else begin
            unique case (tail.op)
                OP_MAP: begin
                    if (tail.dup) begin
                        res_status = ST_EXISTS;
                    end else if (!tail.claimed) begin
                        res_status = ST_FULL;
                    end
                end
                OP_XLATE: begin
                    if (!tail.hit) begin
                        res_status = ST_NOT_FOUND;
                    end else if (tail.deny) begin
                        res_status = ST_PERM;
                    end else begin
                        res_phys = (32'(w_frame[ENTRY_COUNT]) << OFF_W) + 32'(r_off);
                    end
                end
                OP_UNMAP: begin
                    if (!tail.hit) begin
                        res_status = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR: begin
                    res_status = ST_OK;
                end
                default: begin
                    res_status = ST_INVALID;
                end
            endcase
        end
    end

    assign done_to_out = r_done_v && (!r_out_v || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (tail_v) begin
                r_done_v <= 1'b1;
            end else if (done_to_out) begin
                r_done_v <= 1'b0;
            end
            if (done_to_out) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
        if (tail_v) begin
            r_done_status <= res_status;
            r_done_phys   <= res_phys;
        end
        if (done_to_out) begin
            r_out_status <= r_done_status;
            r_out_phys   <= r_done_phys;
        end
    end

    assign o_stall            = r_busy || r_done_v;
    assign o_valid            = r_out_v;
    assign o_status           = r_out_status;
    assign o_physical_address = r_out_phys;

    a_done_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_v |-> o_stall)
        else $error("pending result did not block new requests");

    a_tail_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_v |-> r_busy && !r_done_v)
        else $error("token left the row with no request in flight");

    a_accept_enters_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_tok.valid && r_busy)
        else $error("accepted beat did not enter the row");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.commit && cmd.cancel))
        else $error("commit and cancel together");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_v && (res_status != ST_OK) |-> res_phys == 32'd0)
        else $error("nonzero address on a failed request");

endmodule

// ===== tb/sv/tb.sv =====
// testbench for the page mapping table: directed and random operations against a table model
`timescale 1ns / 1ps

module tb;
    import pmt_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int PAGE_BITS   = 12;
    localparam int ADDR_BITS   = 20;     // 256 pages of 4 KiB
    localparam int SETTLE      = 24;     // row walk plus output register, with margin
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        t_status     status;
        logic [31:0] phys;
    } t_xlate_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_opcode;
    logic [31:0] i_virtual_address;
    logic [31:0] i_frame_address;
    logic [7:0]  i_permission_bits;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [31:0] o_physical_address;
    logic        i_cfg_we;
    logic [7:0]  i_cfg_wdata;

    // table model
    bit       tbl_used  [ENTRIES];
    bit [7:0] tbl_page  [ENTRIES];
    bit [7:0] tbl_frame [ENTRIES];
    bit [7:0] tbl_perm  [ENTRIES];
    bit [7:0] allowed_perms;

    t_xlate_result expected_results[$];
    t_xlate_result want;
    int            mismatches;
    int            cycle_count;
    bit            fast_mode;

    page_mapping_table u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_virtual_address  (i_virtual_address),
        .i_frame_address    (i_frame_address),
        .i_permission_bits  (i_permission_bits),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_physical_address (o_physical_address),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_page[i]  = '0;
            tbl_frame[i] = '0;
            tbl_perm[i]  = '0;
        end
    endfunction

    function automatic bit perms_valid(bit [7:0] p);
        return p != 0 && (p & ~allowed_perms) == 0;
    endfunction

    function automatic bit page_addr_valid(bit [31:0] a);
        return (a >> ADDR_BITS) == 0 && a[PAGE_BITS-1:0] == 0;
    endfunction

    function automatic int find_entry(bit [7:0] page);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_used[i] && tbl_page[i] == page)
                return i;
        return -1;
    endfunction

    function automatic t_xlate_result apply_table_op(t_op op, bit [31:0] va, bit [31:0] fa,
                                                     bit [7:0] pb);
        t_xlate_result r;
        int            idx;
        int            free_idx;
        bit            dup;
        r.status = ST_OK;
        r.phys   = '0;
        free_idx = -1;
        dup      = 1'b0;
        case (op)
            OP_MAP: begin
                if (!page_addr_valid(va) || !page_addr_valid(fa) || !perms_valid(pb)) begin
                    r.status = ST_INVALID;
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (tbl_used[i]) begin
                            if (tbl_page[i] == va[PAGE_BITS +: 8])
                                dup = 1'b1;
                        end else if (free_idx < 0) begin
                            free_idx = i;
                        end
                    end
                    if (dup) begin
                        r.status = ST_EXISTS;
                    end else if (free_idx < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_used[free_idx]  = 1'b1;
                        tbl_page[free_idx]  = va[PAGE_BITS +: 8];
                        tbl_frame[free_idx] = fa[PAGE_BITS +: 8];
                        tbl_perm[free_idx]  = pb;
                    end
                end
            end
            OP_XLATE: begin
                if ((va >> ADDR_BITS) != 0 || !perms_valid(pb)) begin
                    r.status = ST_INVALID;
                end else begin
                    idx = find_entry(va[PAGE_BITS +: 8]);
                    if (idx < 0)
                        r.status = ST_NOT_FOUND;
                    else if ((tbl_perm[idx] & pb) != pb)
                        r.status = ST_PERM;
                    else
                        r.phys = (32'(tbl_frame[idx]) << PAGE_BITS) + 32'(va[PAGE_BITS-1:0]);
                end
            end
            OP_UNMAP: begin
                if (!page_addr_valid(va)) begin
                    r.status = ST_INVALID;
                end else begin
                    idx = find_entry(va[PAGE_BITS +: 8]);
                    if (idx < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        tbl_used[idx]  = 1'b0;
                        tbl_page[idx]  = '0;
                        tbl_frame[idx] = '0;
                        tbl_perm[idx]  = '0;
                    end
                end
            end
            default: wipe_table();
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
        $display("mismatch on %s: got %0h, expected %0h", what, got, exp_val);
        mismatches++;
    endtask

    // valid stays high after a beat so a zero gap never lowers and raises it in one step
    task automatic send_request(t_op op, bit [31:0] va, bit [31:0] fa, bit [7:0] pb);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_virtual_address <= va;
        i_frame_address   <= fa;
        i_permission_bits <= pb;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(apply_table_op(op, va, fa, pb));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_permission_mask(bit [7:0] value);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        allowed_perms = value;
    endtask

    function automatic bit [7:0] pick_page();
        // mostly a small pool so lookups hit and the table fills
        return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
    endfunction

    function automatic bit [7:0] pick_perms();
        bit [7:0] p;
        p = 8'($urandom) & allowed_perms;
        if (p == 0)
            p = $urandom_range(0, 1) ? allowed_perms : 8'($urandom);
        return p;
    endfunction

    task automatic test_map_checks();
        send_request(OP_MAP, 32'h0000_0000, 32'h0000_0000, 8'h01);
        send_request(OP_MAP, 32'h000F_F000, 32'h000F_F000, 8'h07);
        send_request(OP_MAP, 32'h0000_0000, 32'h0000_5000, 8'h02);
        send_request(OP_MAP, 32'h0000_1001, 32'h0000_0000, 8'h01);
        send_request(OP_MAP, 32'h0010_0000, 32'h0000_0000, 8'h01);
        send_request(OP_MAP, 32'h0000_2000, 32'h0010_0000, 8'h01);
        send_request(OP_MAP, 32'h0000_2000, 32'h0000_0800, 8'h01);
        send_request(OP_MAP, 32'h0000_2000, 32'h0000_3000, 8'h00);
        send_request(OP_MAP, 32'h0000_2000, 32'h0000_3000, 8'h08);
        send_request(OP_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        wait_drain();
    endtask

    task automatic test_translate_checks();
        send_request(OP_XLATE, 32'h000F_FFFF, 32'h0, 8'h07);
        send_request(OP_XLATE, 32'h0000_0123, 32'h0, 8'h01);
        send_request(OP_XLATE, 32'h0000_0456, 32'h0, 8'h02);
        send_request(OP_XLATE, 32'h0000_7777, 32'h0, 8'h01);
        send_request(OP_XLATE, 32'h0010_0000, 32'h0, 8'h01);
        send_request(OP_XLATE, 32'h0000_0123, 32'h0, 8'h00);
        send_request(OP_XLATE, 32'h0000_0123, 32'h0, 8'h80);
        wait_drain();
    endtask

    task automatic test_unmap_clear();
        send_request(OP_UNMAP, 32'h0000_0000, 32'h0, 8'h00);
        send_request(OP_UNMAP, 32'h0000_0000, 32'h0, 8'h00);
        send_request(OP_UNMAP, 32'h000F_F001, 32'h0, 8'h00);
        send_request(OP_UNMAP, 32'h0010_0000, 32'h0, 8'h00);
        send_request(OP_CLEAR, 32'h0, 32'h0, 8'h00);
        send_request(OP_XLATE, 32'h000F_F000, 32'h0, 8'h01);
        wait_drain();
    endtask

    task automatic test_permission_mask();
        set_permission_mask(8'hFF);
        send_request(OP_MAP, 32'h0000_5000, 32'h0000_6000, 8'h80);
        send_request(OP_XLATE, 32'h0000_5ABC, 32'h0, 8'h80);
        set_permission_mask(8'h00);
        send_request(OP_XLATE, 32'h0000_5ABC, 32'h0, 8'h80);
        // unmap does not look at permissions
        send_request(OP_UNMAP, 32'h0000_5000, 32'h0, 8'h00);
        wait_drain();
    endtask

    task automatic random_traffic(int count);
        int       n;
        int       sel;
        int       base;
        bit [7:0] page;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 49) == 0)
                fast_mode = !fast_mode;
            sel  = $urandom_range(0, 99);
            page = pick_page();
            if (sel < 2) begin
                // run of distinct pages that overflows the table
                base = $urandom_range(0, 237);
                for (int k = 0; k < ENTRIES + 2; k++)
                    send_request(OP_MAP, 32'(base + k) << PAGE_BITS,
                                 32'($urandom_range(0, 255)) << PAGE_BITS, pick_perms());
                n += ENTRIES + 2;
            end else begin
                if (sel < 37)
                    send_request(OP_MAP, 32'(page) << PAGE_BITS,
                                 32'($urandom_range(0, 255)) << PAGE_BITS, pick_perms());
                else if (sel < 72)
                    send_request(OP_XLATE, (32'(page) << PAGE_BITS) | 32'($urandom_range(0, 4095)),
                                 $urandom, pick_perms());
                else if (sel < 90)
                    send_request(OP_UNMAP, 32'(page) << PAGE_BITS, $urandom, 8'($urandom));
                else if (sel < 93)
                    send_request(OP_CLEAR, $urandom, $urandom, 8'($urandom));
                else
                    send_request(t_op'($urandom_range(0, 3)), $urandom, $urandom, 8'($urandom));
                n++;
            end
        end
        fast_mode = 1'b0;
    endtask

    task automatic test_random_sweep();
        bit [7:0] masks [6];
        int       lens  [6];
        masks = '{8'h07, 8'hFF, 8'h00, 8'h01, 8'($urandom_range(2, 254)), 8'h80};
        lens  = '{160, 180, 40, 130, 200, 150};
        for (int p = 0; p < 6; p++) begin
            set_permission_mask(masks[p]);
            random_traffic(lens[p]);
        end
        wait_drain();
    endtask

    // result side: random stall before each beat
    initial begin
        int hold;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = fast_mode ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_status), 32'h0);
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                if (o_physical_address !== want.phys)
                    report_mismatch("physical_address", o_physical_address, want.phys);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        mismatches        = 0;
        cycle_count       = 0;
        fast_mode         = 1'b0;
        allowed_perms     = 8'h07;
        wipe_table();
        i_rst_n           <= 1'b0;
        i_valid           <= 1'b0;
        i_opcode          <= OP_MAP;
        i_virtual_address <= '0;
        i_frame_address   <= '0;
        i_permission_bits <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_map_checks();
        test_translate_checks();
        test_unmap_clear();
        test_permission_mask();
        test_random_sweep();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== page_mapping_table.f =====
rtl/pmt_pkg.sv
rtl/pmt_cell.sv
rtl/page_mapping_table.sv
tb/sv/tb.sv
